// ===== rtl/core/blle_pkg.sv =====
`timescale 1ns / 1ps
// Package for the bounded list engine: request and result word types,
// request and status codes, and the controller to datapath command and status structs.
// No dependencies.
package blle_pkg;

  localparam int REQ_W = 3;
  localparam int VAL_W = 32;
  localparam int POS_W = 8;
  localparam int STS_W = 2;
  localparam int LEN_W = 7;

  localparam logic [REQ_W-1:0] REQ_APPEND   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DEL_HEAD = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DEL_POS  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DEL_TAIL = 3'd3;
  localparam logic [REQ_W-1:0] REQ_TRAVERSE = 3'd4;

  localparam logic [STS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STS_W-1:0] ST_INVALID = 2'd2;
  localparam logic [STS_W-1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]        req_type;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } in_word_t;

  typedef struct packed {
    logic [STS_W-1:0]        status;
    logic signed [VAL_W-1:0] item;
    logic                    last;
    logic [LEN_W-1:0]        length;
  } out_word_t;

  typedef struct packed {
    logic             append_wr;
    logic             cnt_dec;
    logic             shift_start;
    logic             shift_step;
    logic             trav_start;
    logic             trav_step;
    logic             emit_resp;
    logic [STS_W-1:0] resp_status;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic pos_bad;
    logic del_last;
    logic shift_last;
    logic trav_last;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/core/blle_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the bounded list engine.
// Depends on blle_pkg for request codes and the command and status structs.
module blle_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [blle_pkg::REQ_W-1:0]     in_req,
  output logic                           in_stall,
  input  blle_pkg::dp_sts_t              sts,
  output blle_pkg::cmd_t                 cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_TRAV,
    S_RESP
  } state_t;

  state_t                     state_r, state_nxt;
  logic [blle_pkg::STS_W-1:0] status_r, status_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt        = state_r;
    status_nxt       = status_r;
    cmd              = '0;
    cmd.resp_status  = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt  = S_RESP;
          status_nxt = blle_pkg::ST_OK;
          unique case (in_req) inside
            blle_pkg::REQ_APPEND: begin
              if (sts.cnt_full) begin
                status_nxt = blle_pkg::ST_FULL;
              end else begin
                cmd.append_wr = 1'b1;
              end
            end
            blle_pkg::REQ_DEL_HEAD, blle_pkg::REQ_DEL_POS: begin
              if (sts.cnt_zero) begin
                status_nxt = blle_pkg::ST_EMPTY;
              end else if (in_req == blle_pkg::REQ_DEL_POS && sts.pos_bad) begin
                status_nxt = blle_pkg::ST_INVALID;
              end else if (sts.del_last) begin
                cmd.cnt_dec = 1'b1;
              end else begin
                cmd.shift_start = 1'b1;
                state_nxt       = S_SHIFT;
              end
            end
            blle_pkg::REQ_DEL_TAIL: begin
              if (sts.cnt_zero) begin
                status_nxt = blle_pkg::ST_EMPTY;
              end else begin
                cmd.cnt_dec = 1'b1;
              end
            end
            blle_pkg::REQ_TRAVERSE: begin
              if (sts.cnt_zero) begin
                status_nxt = blle_pkg::ST_EMPTY;
              end else begin
                cmd.trav_start = 1'b1;
                state_nxt      = S_TRAV;
              end
            end
            default: begin
              status_nxt = blle_pkg::ST_OK;
            end
          endcase
        end
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (sts.shift_last) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_RESP;
        end
      end
      S_TRAV: begin
        if (sts.out_free) begin
          cmd.trav_step = 1'b1;
          if (sts.trav_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.emit_resp = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= blle_pkg::ST_OK;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

// ===== rtl/core/blle_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the bounded list engine: entry memory, fill count, index and output register.
// Depends on blle_pkg for word types and the command and status structs.
module blle_dp #(
  parameter int DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  blle_pkg::in_word_t  in_data,
  input  logic                out_stall,
  output logic                out_valid,
  output blle_pkg::out_word_t out_data,
  input  blle_pkg::cmd_t      cmd,
  output blle_pkg::dp_sts_t   sts
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [blle_pkg::VAL_W-1:0] mem [DEPTH];
  logic [blle_pkg::VAL_W-1:0] rdata_r;
  logic [CW-1:0]              count_r, count_nxt;
  logic [AW-1:0]              idx_r, idx_nxt;
  logic                       out_valid_r, out_valid_nxt;
  blle_pkg::out_word_t        out_r, out_nxt;

  logic [blle_pkg::POS_W-1:0] idx_in;
  logic [blle_pkg::POS_W-1:0] count_pos;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [blle_pkg::VAL_W-1:0] wr_data;

  assign count_pos = blle_pkg::POS_W'(count_r);

  always_comb begin
    if (in_data.req_type == blle_pkg::REQ_DEL_HEAD || in_data.position == '0) begin
      idx_in = '0;
    end else begin
      idx_in = in_data.position - blle_pkg::POS_W'(1);
    end
  end

  always_comb begin
    sts.cnt_zero   = (count_r == '0);
    sts.cnt_full   = (count_r == CW'(DEPTH));
    sts.pos_bad    = (idx_in >= count_pos);
    sts.del_last   = (idx_in == count_pos - blle_pkg::POS_W'(1));
    sts.shift_last = (CW'(idx_r) == count_r - CW'(2));
    sts.trav_last  = (CW'(idx_r) == count_r - CW'(1));
    sts.out_free   = !out_valid_r || !out_stall;
  end

  always_comb begin
    rd_en   = cmd.shift_start | cmd.shift_step | cmd.trav_start | cmd.trav_step;
    rd_addr = '0;
    idx_nxt = idx_r;
    wr_en   = 1'b0;
    wr_addr = count_r[AW-1:0];
    wr_data = in_data.value;
    if (cmd.shift_start) begin
      rd_addr = AW'(idx_in + blle_pkg::POS_W'(1));
      idx_nxt = AW'(idx_in);
    end else if (cmd.shift_step) begin
      rd_addr = idx_r + AW'(2);
      idx_nxt = idx_r + AW'(1);
      wr_en   = 1'b1;
      wr_addr = idx_r;
      wr_data = rdata_r;
    end else if (cmd.trav_start) begin
      rd_addr = '0;
      idx_nxt = '0;
    end else if (cmd.trav_step) begin
      rd_addr = idx_r + AW'(1);
      idx_nxt = idx_r + AW'(1);
    end else if (cmd.append_wr) begin
      wr_en = 1'b1;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.append_wr) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    if (cmd.trav_step) begin
      out_valid_nxt  = 1'b1;
      out_nxt.status = blle_pkg::ST_OK;
      out_nxt.item   = rdata_r;
      out_nxt.last   = sts.trav_last;
      out_nxt.length = blle_pkg::LEN_W'(count_r);
    end else if (cmd.emit_resp) begin
      out_valid_nxt  = 1'b1;
      out_nxt.status = cmd.resp_status;
      out_nxt.item   = '0;
      out_nxt.last   = 1'b1;
      out_nxt.length = blle_pkg::LEN_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r <= idx_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/core/bounded_list_engine_unit.sv =====
`timescale 1ns / 1ps
// Bounded list engine top level: controller plus datapath around a DEPTH-word entry memory.
// Append, delete tail and rejected requests go through the response state to a registered result word.
// Delete head or at position shifts the later entries down one place, then responds; position 1 for delete head.
// Traverse delivers one word per cycle while the output is not stalled, after a read start.
// One request at a time; synchronous active-low reset empties the list, no clearing pass.
module bounded_list_engine_unit #(
  parameter int DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  blle_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output blle_pkg::out_word_t out_data
);

  blle_pkg::cmd_t    cmd;
  blle_pkg::dp_sts_t sts;

  blle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_req   (in_data.req_type),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  blle_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
